>>> hdl/gbs_pkg.sv
// gbs_pkg: shared constants and types for the gaussian beam spot pixel generator
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int IMAGE_W = 1024;
    localparam int IMAGE_H = 1024;

    localparam int IN_W     = 24;
    localparam int OUT_W    = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN     = 3'd6;

    localparam int Q16_ONE     = 65536;
    localparam int FALL_LIMIT  = 40960;
    localparam int RECIP5      = 838861;
    localparam int DIV_STEPS   = 33;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_SQ,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic [9:0] col;
        logic [9:0] row;
        logic       in_img;
    } pix_t;

endpackage

>>> hdl/gaussian_beam_spot_pixel_gen.sv
// gaussian_beam_spot_pixel_gen: beam spot pixel generator top level
// throughput: one item per clock through the eight-stage multiply pipeline, unless
// m_tready back-pressure fills it or a reciprocal update holds off the input
// a beam_width or beam_height write starts the shared restoring divider for
// its reciprocal square: input held off from the write cycle until it is written
// reset (rst_n, async, active low) loads the register defaults, empties the pipeline
`timescale 1ns / 1ps

module gaussian_beam_spot_pixel_gen (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [gbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbs_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [gbs_pkg::IN_W-1:0]     s_tdata,   // offset_x, offset_y
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gbs_pkg::OUT_W-1:0]    m_tdata,   // pixel_col, pixel_row, intensity
    output logic [0:0]                   m_tuser    // inside_res
);

    import gbs_pkg::*;

    // configuration
    logic signed [11:0] cx_reg, cy_reg;
    logic [10:0]        bw_reg, bh_reg;
    logic [7:0]         peak_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic [31:0]        inv_w_reg, inv_h_reg;
    logic               pend_w_reg, pend_h_reg;

    // reciprocal divider
    div_state_t  div_state_reg, div_state_next;
    logic        div_start, div_load, div_step, div_wr;
    logic        sel_reg;
    logic [21:0] dd_reg;
    logic [22:0] rem_reg;
    logic [32:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic [10:0] d_sel, d_max;
    logic [22:0] rem_sh;
    logic        rem_ge;
    logic        size_wr;

    // pipeline
    logic [8:1] v_reg;
    logic [9:1] adv;
    logic       in_xfer;

    logic signed [11:0] ox, oy;
    logic signed [27:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic [22:0]        sqx_reg, sqy_reg;
    logic signed [29:0] sc_reg, sr_reg;
    logic [54:0]        mx_reg, my_reg;
    pix_t               pix_reg [3:8];
    logic [15:0]        x_reg;
    logic               clamp_reg;
    logic [16:0]        t_reg [4:6];
    logic [16:0]        t2_reg, t4_reg, t5_reg;
    logic [7:0]         inten_reg;

    logic signed [15:0] cq, rq;
    pix_t               pix_next;
    logic [39:0]        qsum;
    logic [38:0]        drop_prod;
    logic [16:0]        t_next;
    logic [33:0]        t2_prod, t4_prod, t5_prod;
    logic [24:0]        i_prod;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            bw_reg     <= 11'd1;
            bh_reg     <= 11'd1;
            peak_reg   <= 8'd255;
            cos_reg    <= 16'sd16384;
            sin_reg    <= '0;
            pend_w_reg <= 1'b0;
            pend_h_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index == CFG_BEAM_WIDTH))
            begin
                pend_w_reg <= 1'b1;
            end
            else if (div_load && !sel_reg)
            begin
                pend_w_reg <= 1'b0;
            end
            if (cfg_wr_en && (cfg_index == CFG_BEAM_HEIGHT))
            begin
                pend_h_reg <= 1'b1;
            end
            else if (div_load && sel_reg)
            begin
                pend_h_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_CENTER_X:    cx_reg   <= cfg_wdata[11:0];
                    CFG_CENTER_Y:    cy_reg   <= cfg_wdata[11:0];
                    CFG_BEAM_WIDTH:  bw_reg   <= cfg_wdata[10:0];
                    CFG_BEAM_HEIGHT: bh_reg   <= cfg_wdata[10:0];
                    CFG_PEAK_LEVEL:  peak_reg <= cfg_wdata[7:0];
                    CFG_ROT_COS:     cos_reg  <= cfg_wdata;
                    CFG_ROT_SIN:     sin_reg  <= cfg_wdata;
                    default:         ;
                endcase
            end
        end
    end

    // divider next state
    always_comb
    begin
        div_state_next = div_state_reg;
        case (div_state_reg)
            DIV_IDLE: if (pend_w_reg || pend_h_reg) div_state_next = DIV_SQ;
            DIV_SQ:   div_state_next = DIV_RUN;
            DIV_RUN:  if (cnt_reg == 6'd0) div_state_next = DIV_DONE;
            DIV_DONE: div_state_next = DIV_IDLE;
            default:  div_state_next = DIV_IDLE;
        endcase
    end

    // divider controls
    always_comb
    begin
        div_start = 1'b0;
        div_load  = 1'b0;
        div_step  = 1'b0;
        div_wr    = 1'b0;
        case (div_state_reg)
            DIV_IDLE: div_start = pend_w_reg || pend_h_reg;
            DIV_SQ:   div_load  = 1'b1;
            DIV_RUN:  div_step  = 1'b1;
            DIV_DONE: div_wr    = 1'b1;
            default:  ;
        endcase
    end

    assign d_sel  = sel_reg ? bh_reg : bw_reg;
    assign d_max  = (d_sel == 11'd0) ? 11'd1 : d_sel;
    assign rem_sh = {rem_reg[21:0], (cnt_reg == 6'(DIV_STEPS - 1))};
    assign rem_ge = rem_sh >= {1'b0, dd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= DIV_IDLE;
            sel_reg       <= 1'b0;
            inv_w_reg     <= 32'hFFFF_FFFF;
            inv_h_reg     <= 32'hFFFF_FFFF;
        end
        else
        begin
            div_state_reg <= div_state_next;
            if (div_start)
            begin
                sel_reg <= !pend_w_reg;
            end
            if (div_wr && !sel_reg)
            begin
                inv_w_reg <= quo_reg[32] ? 32'hFFFF_FFFF : quo_reg[31:0];
            end
            if (div_wr && sel_reg)
            begin
                inv_h_reg <= quo_reg[32] ? 32'hFFFF_FFFF : quo_reg[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            dd_reg  <= 22'(d_max * d_max);
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= 6'(DIV_STEPS - 1);
        end
        else if (div_step)
        begin
            rem_reg <= rem_ge ? (rem_sh - {1'b0, dd_reg}) : rem_sh;
            quo_reg <= {quo_reg[31:0], rem_ge};
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    // pipeline flow control
    always_comb
    begin
        adv[9] = m_tready;
        for (int k = 8; k >= 1; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign size_wr  = cfg_wr_en && (cfg_index == CFG_BEAM_WIDTH || cfg_index == CFG_BEAM_HEIGHT);
    assign s_tready = adv[1] && (div_state_reg == DIV_IDLE) && !pend_w_reg && !pend_h_reg
                      && !size_wr;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                v_reg[1] <= in_xfer;
            end
            for (int k = 2; k <= 8; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage arithmetic
    assign ox = s_tdata[11:0];
    assign oy = s_tdata[23:12];

    always_comb
    begin
        cq = 16'(sc_reg >>> 14) + 16'((sc_reg[29] && (sc_reg[13:0] != 14'd0)) ? 1 : 0);
        rq = 16'(sr_reg >>> 14) + 16'((sr_reg[29] && (sr_reg[13:0] != 14'd0)) ? 1 : 0);
        pix_next.in_img = !cq[15] && (cq < 16'(IMAGE_W)) && !rq[15] && (rq < 16'(IMAGE_H));
        pix_next.col    = pix_next.in_img ? cq[9:0] : 10'd0;
        pix_next.row    = pix_next.in_img ? rq[9:0] : 10'd0;
        qsum            = 40'(mx_reg[54:16]) + 40'(my_reg[54:16]);
        drop_prod       = 39'({x_reg, 3'b000}) * 39'(RECIP5);
        t_next          = clamp_reg ? 17'd0 : (17'(Q16_ONE) - drop_prod[38:22]);
        t2_prod         = 34'(t_reg[4]) * 34'(t_reg[4]);
        t4_prod         = 34'(t2_reg) * 34'(t2_reg);
        t5_prod         = 34'(t4_reg) * 34'(t_reg[6]);
        i_prod          = 25'(peak_reg) * 25'(t5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            pxc_reg <= 28'(ox * cos_reg);
            pys_reg <= 28'(oy * sin_reg);
            pxs_reg <= 28'(ox * sin_reg);
            pyc_reg <= 28'(oy * cos_reg);
            sqx_reg <= 23'(ox * ox);
            sqy_reg <= 23'(oy * oy);
        end
        if (adv[2])
        begin
            sc_reg <= (30'(cx_reg) <<< 14) + 30'(pxc_reg) - 30'(pys_reg);
            sr_reg <= (30'(cy_reg) <<< 14) + 30'(pxs_reg) + 30'(pyc_reg);
            mx_reg <= 55'(sqx_reg) * 55'(inv_w_reg);
            my_reg <= 55'(sqy_reg) * 55'(inv_h_reg);
        end
        if (adv[3])
        begin
            pix_reg[3] <= pix_next;
            x_reg      <= qsum[15:0];
            clamp_reg  <= qsum >= 40'(FALL_LIMIT);
        end
        if (adv[4])
        begin
            t_reg[4] <= t_next;
        end
        if (adv[5])
        begin
            t2_reg   <= t2_prod[32:16];
            t_reg[5] <= t_reg[4];
        end
        if (adv[6])
        begin
            t4_reg   <= t4_prod[32:16];
            t_reg[6] <= t_reg[5];
        end
        if (adv[7])
        begin
            t5_reg <= t5_prod[32:16];
        end
        if (adv[8])
        begin
            inten_reg <= (i_prod[24:16] > 9'd255) ? 8'd255 : i_prod[23:16];
        end
        for (int k = 4; k <= 8; k++)
        begin
            if (adv[k])
            begin
                pix_reg[k] <= pix_reg[k-1];
            end
        end
    end

    assign m_tvalid = v_reg[8];
    assign m_tdata  = {4'b0000, inten_reg, pix_reg[8].row, pix_reg[8].col};
    assign m_tuser  = pix_reg[8].in_img;

    // checks
    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (div_state_reg == DIV_IDLE))
        else $error("input ready while reciprocal update pending");

    a_width_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr_en && cfg_index == CFG_BEAM_WIDTH) |=> pend_w_reg)
        else $error("beam width write did not request reciprocal update");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[7] && !adv[7]) |=> v_reg[7])
        else $error("stalled stage lost its item");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[19:0] == 20'd0))
        else $error("pixel coordinates not cleared outside the image");

endmodule

>>> test/tb.sv
// tb: self-checking bench for the beam spot pixel generator, offsets in, pixels checked
`timescale 1ns / 1ps

module tb;
    import gbs_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 6;
    localparam int DIV_SETTLE  = 40;
    localparam int DRAIN_WAIT  = 16;
    localparam int HOLD_LEN    = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 100;
    localparam int N_PHASES    = 11;
    localparam int N_FIXED     = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        pix_t       pix;
        logic [7:0] level;
    } spot_t;

    class spot_ledger;
        longint          cx;
        longint          cy;
        longint          cos_q14;
        longint          sin_q14;
        int unsigned     bw;
        int unsigned     bh;
        int unsigned     peak;
        longint unsigned inv_w;
        longint unsigned inv_h;
        spot_t           spots_due[$];
        int              errors;

        function new();
            cx      = 0;
            cy      = 0;
            bw      = 1;
            bh      = 1;
            peak    = 255;
            cos_q14 = 16384;
            sin_q14 = 0;
            inv_w   = inv_square(bw);
            inv_h   = inv_square(bh);
            errors  = 0;
        endfunction

        function longint unsigned inv_square(int unsigned d);
            longint unsigned dd;
            longint unsigned r;
            if (d == 0)
            begin
                d = 1;
            end
            dd = longint'(d) * longint'(d);
            r  = (64'd1 << 32) / dd;
            if (r > 64'hFFFF_FFFF)
            begin
                r = 64'hFFFF_FFFF;
            end
            return r;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_CENTER_X:    cx = longint'($signed(v[11:0]));
                CFG_CENTER_Y:    cy = longint'($signed(v[11:0]));
                CFG_BEAM_WIDTH:
                begin
                    bw    = v[10:0];
                    inv_w = inv_square(bw);
                end
                CFG_BEAM_HEIGHT:
                begin
                    bh    = v[10:0];
                    inv_h = inv_square(bh);
                end
                CFG_PEAK_LEVEL:  peak = v[7:0];
                CFG_ROT_COS:     cos_q14 = longint'($signed(v));
                CFG_ROT_SIN:     sin_q14 = longint'($signed(v));
                default:         ;
            endcase
        endfunction

        function spot_t render_spot(logic [11:0] ox_raw, logic [11:0] oy_raw);
            longint          ox;
            longint          oy;
            longint          sc;
            longint          sr;
            longint          col;
            longint          row;
            longint unsigned sqx;
            longint unsigned sqy;
            longint unsigned qx;
            longint unsigned qy;
            longint unsigned drop;
            longint unsigned t;
            longint unsigned t2;
            longint unsigned t4;
            longint unsigned t5;
            longint unsigned lvl;
            logic            in_img;
            spot_t           r;
            ox     = longint'($signed(ox_raw));
            oy     = longint'($signed(oy_raw));
            sc     = cx * 16384 + ox * cos_q14 - oy * sin_q14;
            sr     = cy * 16384 + ox * sin_q14 + oy * cos_q14;
            col    = sc / 16384;
            row    = sr / 16384;
            in_img = (col >= 0) && (col < IMAGE_W) && (row >= 0) && (row < IMAGE_H);
            sqx    = ox * ox;
            sqy    = oy * oy;
            qx     = (sqx * inv_w) >> 16;
            qy     = (sqy * inv_h) >> 16;
            drop   = ((qx + qy) * 8) / 5;
            if (drop >= Q16_ONE)
            begin
                lvl = 0;
            end
            else
            begin
                t   = Q16_ONE - drop;
                t2  = (t * t) >> 16;
                t4  = (t2 * t2) >> 16;
                t5  = (t4 * t) >> 16;
                lvl = (longint'(peak) * t5) >> 16;
                if (lvl > 255)
                begin
                    lvl = 255;
                end
            end
            r.pix.col    = in_img ? col[9:0] : 10'd0;
            r.pix.row    = in_img ? row[9:0] : 10'd0;
            r.pix.in_img = in_img;
            r.level      = lvl[7:0];
            return r;
        endfunction

        function void note_offset(logic [11:0] ox, logic [11:0] oy);
            spots_due.push_back(render_spot(ox, oy));
        endfunction

        task report_mismatch(string msg);
            if (errors < 40)
            begin
                $display("[%0t] %s", $time, msg);
            end
            errors++;
        endtask

        task check_pixel(logic [OUT_W-1:0] data, logic [0:0] user);
            spot_t e;
            if (spots_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer data=%h user=%b", data, user));
                return;
            end
            e = spots_due.pop_front();
            if (data[9:0] !== e.pix.col)
            begin
                report_mismatch($sformatf("pixel_col %0d, want %0d", data[9:0], e.pix.col));
            end
            if (data[19:10] !== e.pix.row)
            begin
                report_mismatch($sformatf("pixel_row %0d, want %0d", data[19:10], e.pix.row));
            end
            if (data[27:20] !== e.level)
            begin
                report_mismatch($sformatf("intensity %0d, want %0d", data[27:20], e.level));
            end
            if (data[31:28] !== 4'd0)
            begin
                report_mismatch($sformatf("tdata padding %h, want 0", data[31:28]));
            end
            if (user[0] !== e.pix.in_img)
            begin
                report_mismatch($sformatf("inside_res %b, want %b", user[0], e.pix.in_img));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic [0:0]           m_tuser;

    spot_ledger ledger = new();
    bit         hold_sink;
    int         quiet_cycles;
    int         src_burst;
    int         sink_burst;

    gaussian_beam_spot_pixel_gen u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("gaussian_beam_spot_pixel_gen: mismatch");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ledger.set_reg(idx, val);
        // reciprocal square recompute runs after a size write
        if (idx == CFG_BEAM_WIDTH || idx == CFG_BEAM_HEIGHT)
        begin
            repeat (DIV_SETTLE) @(posedge clk);
        end
    endtask

    task automatic apply_setting(int px, int py, int w, int h, int pk, int c, int s);
        write_reg(CFG_CENTER_X, 16'(px) & 16'h0FFF);
        write_reg(CFG_CENTER_Y, 16'(py) & 16'h0FFF);
        write_reg(CFG_BEAM_WIDTH, 16'(w) & 16'h07FF);
        write_reg(CFG_BEAM_HEIGHT, 16'(h) & 16'h07FF);
        write_reg(CFG_PEAK_LEVEL, 16'(pk) & 16'h00FF);
        write_reg(CFG_ROT_COS, 16'(c));
        write_reg(CFG_ROT_SIN, 16'(s));
    endtask

    task automatic random_setting();
        int  px;
        int  py;
        int  w;
        int  h;
        int  c;
        int  s;
        real ang;
        px  = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 1023))
                                         : int'($urandom_range(0, 4095)) - 2048;
        py  = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 1023))
                                         : int'($urandom_range(0, 4095)) - 2048;
        w   = ($urandom_range(0, 9) < 7) ? int'($urandom_range(1, 600))
                                         : int'($urandom_range(0, 2047));
        h   = ($urandom_range(0, 9) < 7) ? int'($urandom_range(1, 600))
                                         : int'($urandom_range(0, 2047));
        if ($urandom_range(0, 9) < 6)
        begin
            ang = real'($urandom_range(0, 359)) * 3.14159265358979 / 180.0;
            c   = $rtoi(16384.0 * $cos(ang));
            s   = $rtoi(16384.0 * $sin(ang));
        end
        else
        begin
            c = int'($urandom_range(0, 65535)) - 32768;
            s = int'($urandom_range(0, 65535)) - 32768;
        end
        apply_setting(px, py, w, h, $urandom_range(0, 255), c, s);
    endtask

    task automatic fixed_setting(int idx);
        case (idx)
            0: apply_setting(512, 512, 400, 300, 200, 16384, 0);
            1:
            begin
                apply_setting(300, 700, 800, 200, 255, 14189, 8192);
                write_reg(CFG_UNUSED, 16'hFFFF);
            end
            2: apply_setting(1023, 0, 64, 64, 255, 11585, -11585);
            3: apply_setting(-2048, 2047, 0, 2047, 0, -32768, 32767);
            4: apply_setting(0, 0, 2047, 2047, 255, 0, -16384);
            default: apply_setting(512, 300, 1, 1, 1, 16384, 16384);
        endcase
    endtask

    task automatic send_offset(int ox, int oy);
        int gap;
        if (hold_sink || src_burst > 0)
        begin
            gap = 0;
            if (src_burst > 0)
            begin
                src_burst--;
            end
        end
        else
        begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0)
            begin
                src_burst = $urandom_range(20, 60);
            end
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {12'(oy), 12'(ox)};
        do
            @(posedge clk);
        while (!s_tready);
        ledger.note_offset(12'(ox), 12'(oy));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (ledger.spots_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic int rand_offset(int unsigned span);
        int v;
        int sel;
        sel = $urandom_range(0, 9);
        if (span == 0)
        begin
            span = 1;
        end
        if (sel < 6)
        begin
            v = int'($urandom_range(0, 2 * span)) - int'(span);
            if (v > 2047)
            begin
                v = 2047;
            end
            if (v < -2048)
            begin
                v = -2048;
            end
        end
        else if (sel < 9)
        begin
            v = int'($urandom_range(0, 2458)) - 1229;
        end
        else
        begin
            v = int'($urandom_range(0, 4095)) - 2048;
        end
        return v;
    endfunction

    initial
    begin : sink
        int stall;
        m_tready <= 1'b0;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (sink_burst > 0)
            begin
                sink_burst--;
            end
            else
            begin
                stall = $urandom_range(0, 6);
                if ($urandom_range(0, 19) == 0)
                begin
                    sink_burst = $urandom_range(20, 60);
                end
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            ledger.check_pixel(m_tdata, m_tuser);
        end
    end

    initial
    begin : stim
        int ph;
        int n;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        hold_sink  = 1'b0;
        src_burst  = 0;
        sink_burst = 0;
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset defaults: unit beam, untilted, centre at the origin
        send_offset(0, 0);
        send_offset(1, 0);
        send_offset(-1, -1);
        drain();

        apply_setting(512, 512, 400, 300, 255, 16384, 0);
        send_offset(0, 0);
        send_offset(2047, 0);
        send_offset(-2048, 0);
        send_offset(0, 2047);
        send_offset(0, -2048);
        send_offset(1229, 1229);
        send_offset(-1229, -1229);
        send_offset(100, 50);
        // either side of the falloff reaching zero
        send_offset(316, 0);
        send_offset(317, 0);
        // image corners and just past the right edge
        send_offset(-512, -512);
        send_offset(511, 511);
        send_offset(512, 0);
        drain();

        // zero height and tilt beyond unit range
        apply_setting(100, 100, 2047, 0, 128, -32768, 32767);
        send_offset(0, 0);
        send_offset(1, 1);
        send_offset(-1, 2047);
        send_offset(2047, -2048);
        send_offset(0, 1);
        drain();

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph < N_FIXED)
            begin
                fixed_setting(ph);
            end
            else
            begin
                random_setting();
            end
            if (ph == 2)
            begin
                hold_sink = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                begin
                    drain();
                end
                send_offset(rand_offset(ledger.bw), rand_offset(ledger.bh));
            end
            drain();
        end

        if (ledger.errors == 0 && ledger.spots_due.size() == 0)
        begin
            $display("gaussian_beam_spot_pixel_gen: match");
        end
        else
        begin
            $display("gaussian_beam_spot_pixel_gen: mismatch");
        end
        $finish;
    end

endmodule

>>> gaussian_beam_spot_pixel_gen.f
hdl/gbs_pkg.sv
hdl/gaussian_beam_spot_pixel_gen.sv
test/tb.sv
